### design/mga_pkg.sv
// ---------------------------------------------------------------------------
// mga_pkg
// Shared widths, register codes and beat types for the Mycielski graph
// adjacency block.
// ---------------------------------------------------------------------------
package mga_pkg;

   // default ceiling on the constructed graph's vertex count
   localparam int MAX_VERTICES_DEFAULT = 1024;

   // field widths
   localparam int VTX_W     = 10;
   localparam int CFG_W     = 10;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLIQUE_SIZE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMATIC_NUMBER = 2'd1;

   // query beat
   typedef struct packed {
      logic [VTX_W-1:0] row_vertex;
      logic [VTX_W-1:0] col_vertex;
   } req_type;

   // answer beat
   typedef struct packed {
      logic adjacent;
      logic in_range;
   } rsp_type;

   // per-item status carried down the level pipeline
   typedef struct packed {
      logic done;      // answer already settled
      logic adjacent;  // settled answer
      logic in_range;  // query valid for the configured graph
   } flags_type;

endpackage

### design/mga_level.sv
// ---------------------------------------------------------------------------
// mga_level
// One level of the Mycielski descent as a pipeline stage: resolves hub and
// shadow-pair cases, or folds shadow vertices onto their originals.
// ---------------------------------------------------------------------------
module mga_level #(
   parameter int VW = 11
) (
   input  logic                clock,
   input  logic                reset,
   // upstream side
   input  logic                up_valid,
   output logic                up_ready,
   input  logic [VW-1:0]       up_a,
   input  logic [VW-1:0]       up_b,
   input  mga_pkg::flags_type  up_flags,
   // level description
   input  logic                active,
   input  logic [VW-1:0]       half,
   // downstream side
   output logic                dn_valid,
   input  logic                dn_ready,
   output logic [VW-1:0]       dn_a,
   output logic [VW-1:0]       dn_b,
   output mga_pkg::flags_type  dn_flags
);

   logic               valid_ff;
   logic [VW-1:0]      a_ff, b_ff, a_in, b_in;
   mga_pkg::flags_type flags_ff, flags_in;
   logic [VW-1:0]      hub;
   logic               sa, sb;

   // hub of this level sits at twice the lower half size
   assign hub = {half[VW-2:0], 1'b0};
   assign sa  = (up_a >= half);
   assign sb  = (up_b >= half);

   // one descent step
   always_comb begin
      a_in     = up_a;
      b_in     = up_b;
      flags_in = up_flags;
      if (active && !up_flags.done) begin
         if (up_a == hub) begin
            flags_in.done     = 1'b1;
            flags_in.adjacent = sb && (up_b < hub);
         end else if (up_b == hub) begin
            flags_in.done     = 1'b1;
            flags_in.adjacent = sa && (up_a < hub);
         end else if (sa && sb) begin
            flags_in.done     = 1'b1;
            flags_in.adjacent = 1'b0;
         end else begin
            if (sa) a_in = up_a - half;
            if (sb) b_in = up_b - half;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         flags_ff <= flags_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_a     = a_ff;
   assign dn_b     = b_ff;
   assign dn_flags = flags_ff;

   // a settled answer passes through untouched
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (up_valid && up_ready && up_flags.done) |=> (dn_flags == $past(up_flags)))
      else $error("settled answer altered in level stage");

   // an idle level is a plain delay
   a_idle_pass: assert property (@(posedge clock) disable iff (reset)
      (up_valid && up_ready && !active) |=>
         (dn_a == $past(up_a) && dn_b == $past(up_b) && dn_flags == $past(up_flags)))
      else $error("inactive level changed the beat");

   // an unsettled item leaves the level inside the lower half
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      (up_valid && up_ready && active && !up_flags.done) |=>
         (dn_flags.done || (dn_a < $past(half) && dn_b < $past(half))))
      else $error("folded index outside lower half");

endmodule

### design/mycielski_graph_adjacency.sv
// ---------------------------------------------------------------------------
// mycielski_graph_adjacency
// Adjacency queries on the graph made by iterating the Mycielski
// construction from a complete graph, one query per cycle unless stalled.
// ---------------------------------------------------------------------------
//  channel | ports                         | beat
//  --------+-------------------------------+------------------------------
//  query   | req_valid req_ready req_data  | row_vertex, col_vertex
//  answer  | rsp_valid rsp_ready rsp_data  | adjacent, in_range
//  config  | csr_valid csr_ready csr_index | csr_wdata to register index
//
//  The pipe holds an entry stage, one stage per construction level and an
//  output register; NLEV is 10 at MAX_VERTICES = 1024. A new query is taken
//  every cycle unless the pipe stalls; the level pipeline sets throughput.
//  Reset is synchronous: both registers return to 1 and the pipe empties;
//  req_ready and csr_ready stay low while reset is high.
//  A stall on the answer side backs up stage by stage without loss.
// ---------------------------------------------------------------------------
module mycielski_graph_adjacency #(
   parameter int MAX_VERTICES = mga_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // query channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mga_pkg::req_type                    req_data,
   // answer channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mga_pkg::rsp_type                    rsp_data,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mga_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mga_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int VW   = $clog2(MAX_VERTICES + 1);
   localparam int NLEV = $clog2(MAX_VERTICES + 2) - 1;
   localparam int LW   = $clog2(NLEV + 1);
   localparam int PW   = mga_pkg::CFG_W + 1 + NLEV;
   localparam int EW   = (VW > mga_pkg::VTX_W) ? VW : mga_pkg::VTX_W;

   // configuration and derived graph shape
   logic [mga_pkg::CFG_W-1:0] clique_ff, clique_in, chrom_ff, chrom_in;
   logic [mga_pkg::CFG_W-1:0] lev_wide;
   logic [PW-1:0]             prod, total_wide;
   logic                      ok_ff, ok_in;
   logic [VW-1:0]             total_ff, total_in;
   logic [LW-1:0]             lev_ff, lev_in;
   logic [VW-1:0]             half_ff [NLEV];
   logic [VW-1:0]             half_in [NLEV];

   assign csr_ready = !reset;

   // next register values
   always_comb begin
      clique_in = clique_ff;
      chrom_in  = chrom_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mga_pkg::CSR_CLIQUE_SIZE:      clique_in = csr_wdata;
            mga_pkg::CSR_CHROMATIC_NUMBER: chrom_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // vertex count after L levels is (clique + 1) * 2^L - 1
   always_comb begin
      lev_wide   = chrom_in - clique_in;
      prod       = PW'({1'b0, clique_in} + 11'd1) << lev_wide[LW-1:0];
      total_wide = prod - PW'(1);
      ok_in      = (chrom_in >= clique_in)
                   && (lev_wide <= mga_pkg::CFG_W'(NLEV))
                   && (total_wide <= PW'(MAX_VERTICES));
      total_in   = VW'(total_wide);
      lev_in     = lev_wide[LW-1:0];
      for (int s = 0; s < NLEV; s++) begin
         half_in[s] = VW'((prod >> (s + 1)) - PW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clique_ff <= mga_pkg::CFG_W'(1);
         chrom_ff  <= mga_pkg::CFG_W'(1);
         ok_ff     <= 1'b1;
         total_ff  <= VW'(1);
         lev_ff    <= '0;
      end else begin
         clique_ff <= clique_in;
         chrom_ff  <= chrom_in;
         ok_ff     <= ok_in;
         total_ff  <= total_in;
         lev_ff    <= lev_in;
      end
      for (int s = 0; s < NLEV; s++) begin
         half_ff[s] <= half_in[s];
      end
   end

   // pipeline wiring: index 0 is the entry stage, index NLEV the last level
   logic               valid_s [NLEV+1];
   logic               ready_s [NLEV+1];
   logic [VW-1:0]      a_s     [NLEV+1];
   logic [VW-1:0]      b_s     [NLEV+1];
   mga_pkg::flags_type flags_s [NLEV+1];

   // entry stage: range check and mirroring
   logic               e_valid_ff;
   logic [VW-1:0]      e_a_ff, e_b_ff, e_a_in, e_b_in;
   mga_pkg::flags_type e_flags_ff, e_flags_in;
   logic [EW-1:0]      row_ext, col_ext, total_ext;

   assign row_ext   = EW'(req_data.row_vertex);
   assign col_ext   = EW'(req_data.col_vertex);
   assign total_ext = EW'(total_ff);

   always_comb begin
      e_flags_in.in_range = ok_ff && (row_ext < total_ext) && (col_ext < total_ext);
      e_flags_in.done     = !e_flags_in.in_range;
      e_flags_in.adjacent = 1'b0;
      e_a_in              = VW'(total_ext - row_ext - EW'(1));
      e_b_in              = VW'(total_ext - col_ext - EW'(1));
   end

   assign req_ready = !reset && (!e_valid_ff || ready_s[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (req_ready) begin
         e_valid_ff <= req_valid;
      end
      if (req_ready) begin
         e_a_ff     <= e_a_in;
         e_b_ff     <= e_b_in;
         e_flags_ff <= e_flags_in;
      end
   end

   assign valid_s[0] = e_valid_ff;
   assign a_s[0]     = e_a_ff;
   assign b_s[0]     = e_b_ff;
   assign flags_s[0] = e_flags_ff;

   // one stage per construction level, outermost first
   for (genvar s = 0; s < NLEV; s++) begin : g_level
      mga_level #(
         .VW (VW)
      ) u_level (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_s[s]),
         .up_ready (ready_s[s]),
         .up_a     (a_s[s]),
         .up_b     (b_s[s]),
         .up_flags (flags_s[s]),
         .active   (LW'(s) < lev_ff),
         .half     (half_ff[s]),
         .dn_valid (valid_s[s+1]),
         .dn_ready (ready_s[s+1]),
         .dn_a     (a_s[s+1]),
         .dn_b     (b_s[s+1]),
         .dn_flags (flags_s[s+1])
      );
   end

   // output register: base case is the complete graph
   logic             out_valid_ff;
   mga_pkg::rsp_type out_ff, out_in;

   always_comb begin
      out_in.in_range = flags_s[NLEV].in_range;
      out_in.adjacent = flags_s[NLEV].done ? flags_s[NLEV].adjacent
                                           : (a_s[NLEV] != b_s[NLEV]);
   end

   assign ready_s[NLEV] = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ready_s[NLEV]) begin
         out_valid_ff <= valid_s[NLEV];
      end
      if (ready_s[NLEV]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // out-of-range answers are never adjacent
   a_range_adj: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.in_range) |-> !rsp_data.adjacent)
      else $error("out-of-range answer marked adjacent");

   // a valid graph never needs more levels than the pipe has
   a_lev_fits: assert property (@(posedge clock) disable iff (reset)
      ok_ff |-> (lev_ff <= LW'(NLEV)))
      else $error("level count exceeds pipeline depth");

   // a query on an invalid graph enters already settled as out of range
   a_bad_graph: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !ok_ff) |=> (!flags_s[0].in_range && flags_s[0].done))
      else $error("query on invalid graph not flagged");

endmodule
